### hdl/rstrk_pkg.sv
// Shared types and codes for the request slot tracker.
package rstrk_pkg;

  // Request commands.
  typedef enum logic [2:0] {
    CMD_ISSUE    = 3'd0,
    CMD_TAKE     = 3'd1,
    CMD_CANCEL   = 3'd2,
    CMD_COMPLETE = 3'd3,
    CMD_COLLECT  = 3'd4
  } cmd_e;

  // Result status codes.
  typedef enum logic [2:0] {
    STS_OK       = 3'd0,
    STS_FULL     = 3'd1,
    STS_NONE     = 3'd2,
    STS_NOT_PROC = 3'd3,
    STS_NOT_DONE = 3'd4
  } res_status_e;

  // Life cycle of one slot.
  typedef enum logic [1:0] {
    SLOT_IDLE       = 2'd0,
    SLOT_PENDING    = 2'd1,
    SLOT_PROCESSING = 2'd2,
    SLOT_COMPLETE   = 2'd3
  } slot_state_e;

  // Controller states.
  typedef enum logic [2:0] {
    FSM_CLEAR,
    FSM_IDLE,
    FSM_SCAN,
    FSM_LOOKUP,
    FSM_APPLY,
    FSM_FETCH
  } fsm_e;

  typedef struct packed {
    logic [2:0]  command;
    logic [6:0]  slot;
    logic [63:0] request_handle;
    logic [63:0] return_value;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [6:0]  slot_out;
    logic [63:0] handle_out;
    logic [63:0] value_out;
    logic [7:0]  pending_out;
  } res_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;
    logic latch;
    logic scan_start;
    logic scan_step;
    logic commit;
    logic fail;
    logic lookup;
    logic apply;
    logic fetch;
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_done;
    logic new_is_scan;
    logic is_take;
    logic hit;
    logic miss;
  } dp_stat_t;

endpackage

### hdl/request_slot_tracker_top.sv
// Top level of the request slot tracker: controller, datapath and their wiring.
//
// The request slot tracker keeps a table of SLOTS slots, each idle, pending,
// processing or complete, and serves one request at a time. A request is taken
// when start is high while busy is low, and its result is presented on res_o for
// exactly one cycle, marked by done_o; the receiver cannot hold a result off, so it
// must capture res_o whenever done_o is high. Issue and take search the slot status
// table from the shared scan pointer, one slot per cycle through the status RAM's
// single registered read port, so their latency depends on how many slots are
// stepped over; take, once it finds its slot, then reads the stored handle before
// reporting, and a search that finds nothing reports after checking every slot.
// Cancel, complete and collect read the slot's status, then update it, and report.
// The next request may be presented in the very cycle its predecessor's result is
// shown. After reset the block first walks the status table to mark every slot
// idle, which keeps busy high until the walk is done.
module request_slot_tracker_top #(
  parameter int unsigned SLOTS = 128
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  rstrk_pkg::req_t req_i,
  output logic            done_o,
  output rstrk_pkg::res_t res_o
);
  import rstrk_pkg::*;

  ctl_cmd_t ctl_cmd;
  dp_stat_t dp_stat;

  // The controller sequences each request; of the datapath it sees only the status.
  rstrk_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .stat_i (dp_stat),
    .cmd_o  (ctl_cmd)
  );

  // The datapath holds the slot tables, the scan pointer and the pending count.
  rstrk_dp #(.SLOTS(SLOTS)) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (ctl_cmd),
    .stat_o (dp_stat),
    .req_i  (req_i),
    .done_o (done_o),
    .res_o  (res_o)
  );

  // An accepted request makes the block busy in the following cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("request accepted but block not busy");

  // Each request produces a single one-cycle result strobe.
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held for more than one cycle");

  // A result is only presented once the block is ready for the next request.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result presented while busy");

endmodule

### hdl/rstrk_ram.sv
// Generic single write port, single read port RAM with registered read data.
module rstrk_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/rstrk_ctrl.sv
// Controller state machine of the request slot tracker.
module rstrk_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  rstrk_pkg::dp_stat_t stat_i,
  output rstrk_pkg::ctl_cmd_t cmd_o
);
  import rstrk_pkg::*;

  fsm_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FSM_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy    = 1'b1;
    case (state_q)
      FSM_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (stat_i.clear_done) begin
          state_d = FSM_IDLE;
        end
      end
      FSM_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd_o.latch = 1'b1;
          if (stat_i.new_is_scan) begin
            cmd_o.scan_start = 1'b1;
            state_d          = FSM_SCAN;
          end else begin
            state_d = FSM_LOOKUP;
          end
        end
      end
      FSM_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (stat_i.hit) begin
          cmd_o.commit = 1'b1;
          state_d      = stat_i.is_take ? FSM_FETCH : FSM_IDLE;
        end else if (stat_i.miss) begin
          cmd_o.fail = 1'b1;
          state_d    = FSM_IDLE;
        end
      end
      FSM_LOOKUP: begin
        cmd_o.lookup = 1'b1;
        state_d      = FSM_APPLY;
      end
      FSM_APPLY: begin
        cmd_o.apply = 1'b1;
        state_d     = FSM_IDLE;
      end
      FSM_FETCH: begin
        cmd_o.fetch = 1'b1;
        state_d     = FSM_IDLE;
      end
      default: begin
        state_d = FSM_IDLE;
      end
    endcase
  end

endmodule

### hdl/rstrk_dp.sv
// Datapath of the request slot tracker: slot tables, scan pointer, count and result.
module rstrk_dp #(
  parameter int unsigned SLOTS = 128
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rstrk_pkg::ctl_cmd_t cmd_i,
  output rstrk_pkg::dp_stat_t stat_o,
  input  rstrk_pkg::req_t     req_i,
  output logic                done_o,
  output rstrk_pkg::res_t     res_o
);
  import rstrk_pkg::*;

  localparam int unsigned IW  = $clog2(SLOTS);
  localparam int unsigned CW  = $clog2(SLOTS + 1);
  localparam int unsigned SLW = (IW > 7) ? IW : 7;
  localparam int unsigned PW  = (CW > 8) ? CW : 8;
  localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);

  req_t          req_q, req_d;
  logic [IW-1:0] ptr_q, ptr_d;
  logic [IW-1:0] probe_q, probe_d;
  logic [IW-1:0] cand_q, cand_d;
  logic          cand_v_q, cand_v_d;
  logic [IW-1:0] chk_q, chk_d;
  logic [IW-1:0] clr_q, clr_d;
  logic [CW-1:0] pend_q, pend_d;
  res_t          res_q, res_d;
  logic          done_q, done_d;

  logic          st_we;
  logic [IW-1:0] st_waddr, st_raddr;
  slot_state_e   st_wdata;
  logic [1:0]    st_rdata;
  logic          h_we, v_we;
  logic [63:0]   h_rdata, v_rdata;

  logic [SLW-1:0] slot_ext, cand_ext;
  logic [IW-1:0]  slot_addr;
  logic           slot_ok;
  logic           is_take;
  slot_state_e    want;
  logic           match;

  assign slot_ext  = SLW'(req_q.slot);
  assign slot_addr = slot_ext[IW-1:0];
  assign slot_ok   = (32'(req_q.slot) < 32'(SLOTS));
  assign cand_ext  = SLW'(cand_q);
  assign is_take   = (req_q.command == CMD_TAKE);
  assign want      = is_take ? SLOT_PENDING : SLOT_IDLE;
  assign match     = cand_v_q && (st_rdata == want);

  assign stat_o.clear_done  = (clr_q == LAST);
  assign stat_o.new_is_scan = (req_i.command == CMD_ISSUE) || (req_i.command == CMD_TAKE);
  assign stat_o.is_take     = is_take;
  assign stat_o.hit         = match;
  assign stat_o.miss        = cand_v_q && !match && (chk_q == LAST);

  assign st_raddr = cmd_i.lookup ? slot_addr : probe_q;

  rstrk_ram #(.WIDTH(2), .DEPTH(SLOTS)) u_status_ram (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  rstrk_ram #(.WIDTH(64), .DEPTH(SLOTS)) u_handle_ram (
    .clk_i   (clk_i),
    .we_i    (h_we),
    .waddr_i (cand_q),
    .wdata_i (req_q.request_handle),
    .raddr_i (cand_q),
    .rdata_o (h_rdata)
  );

  rstrk_ram #(.WIDTH(64), .DEPTH(SLOTS)) u_value_ram (
    .clk_i   (clk_i),
    .we_i    (v_we),
    .waddr_i (slot_addr),
    .wdata_i (req_q.return_value),
    .raddr_i (slot_addr),
    .rdata_o (v_rdata)
  );

  always_comb begin
    logic [PW-1:0] pend_wide;
    req_d    = req_q;
    ptr_d    = ptr_q;
    probe_d  = probe_q;
    cand_d   = cand_q;
    cand_v_d = cand_v_q;
    chk_d    = chk_q;
    clr_d    = clr_q;
    pend_d   = pend_q;
    res_d    = res_q;
    done_d   = 1'b0;
    st_we    = 1'b0;
    st_waddr = cand_q;
    st_wdata = SLOT_IDLE;
    h_we     = 1'b0;
    v_we     = 1'b0;

    if (cmd_i.clear) begin
      st_we    = 1'b1;
      st_waddr = clr_q;
      clr_d    = clr_q + 1'b1;
    end

    if (cmd_i.latch) begin
      req_d = req_i;
    end

    if (cmd_i.scan_start) begin
      probe_d  = ptr_q;
      cand_v_d = 1'b0;
      chk_d    = '0;
    end

    if (cmd_i.scan_step) begin
      if (is_take) begin
        probe_d = (probe_q == '0) ? LAST : probe_q - 1'b1;
      end else begin
        probe_d = (probe_q == LAST) ? '0 : probe_q + 1'b1;
      end
      cand_d   = probe_q;
      cand_v_d = 1'b1;
      if (cand_v_q) begin
        chk_d = chk_q + 1'b1;
      end
    end

    if (cmd_i.commit) begin
      st_we            = 1'b1;
      st_waddr         = cand_q;
      ptr_d            = cand_q;
      res_d.status     = STS_OK;
      res_d.slot_out   = cand_ext[6:0];
      res_d.handle_out = '0;
      res_d.value_out  = '0;
      if (is_take) begin
        st_wdata = SLOT_PROCESSING;
        if (pend_q != '0) begin
          pend_d = pend_q - 1'b1;
        end
      end else begin
        st_wdata = SLOT_PENDING;
        h_we     = 1'b1;
        pend_d   = pend_q + 1'b1;
        done_d   = 1'b1;
      end
    end

    if (cmd_i.fail) begin
      res_d.status     = is_take ? STS_NONE : STS_FULL;
      res_d.slot_out   = '0;
      res_d.handle_out = '0;
      res_d.value_out  = '0;
      done_d           = 1'b1;
    end

    if (cmd_i.fetch) begin
      res_d.handle_out = h_rdata;
      done_d           = 1'b1;
    end

    if (cmd_i.apply) begin
      st_waddr         = slot_addr;
      res_d.status     = STS_OK;
      res_d.slot_out   = '0;
      res_d.handle_out = '0;
      res_d.value_out  = '0;
      done_d           = 1'b1;
      case (req_q.command)
        CMD_CANCEL: begin
          if (slot_ok) begin
            st_we = 1'b1;
            if ((st_rdata == SLOT_PENDING) && (pend_q != '0)) begin
              pend_d = pend_q - 1'b1;
            end
          end
        end
        CMD_COMPLETE: begin
          if (slot_ok && (st_rdata == SLOT_PROCESSING)) begin
            st_we    = 1'b1;
            st_wdata = SLOT_COMPLETE;
            v_we     = 1'b1;
          end else begin
            res_d.status = STS_NOT_PROC;
          end
        end
        CMD_COLLECT: begin
          if (slot_ok && (st_rdata == SLOT_COMPLETE)) begin
            st_we           = 1'b1;
            res_d.value_out = v_rdata;
          end else begin
            res_d.status = STS_NOT_DONE;
          end
        end
        default: begin
        end
      endcase
    end

    pend_wide = PW'(pend_d);
    if (cmd_i.commit || cmd_i.fail || cmd_i.apply) begin
      res_d.pending_out = pend_wide[7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q    <= '0;
      cand_v_q <= 1'b0;
      chk_q    <= '0;
      clr_q    <= '0;
      pend_q   <= '0;
      done_q   <= 1'b0;
    end else begin
      ptr_q    <= ptr_d;
      cand_v_q <= cand_v_d;
      chk_q    <= chk_d;
      clr_q    <= clr_d;
      pend_q   <= pend_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q   <= req_d;
    probe_q <= probe_d;
    cand_q  <= cand_d;
    res_q   <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  // The pending count can never exceed the number of slots.
  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(pend_q) <= 32'(SLOTS))
    else $error("pending count above slot count");

  // A successful scan leaves the scan pointer on the slot it found.
  a_ptr_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |=> (ptr_q == $past(cand_q)))
    else $error("scan pointer did not move to the slot found");

endmodule

### test/tb_request_slot_tracker_top.sv
// Self-checking testbench for the request slot tracker: directed, full-table and random requests.
`timescale 1ns / 100ps

module tb_request_slot_tracker_top;
  import rstrk_pkg::*;

  localparam int unsigned SLOTS = 128;
  localparam int unsigned MAX_GAP = 7;
  localparam int unsigned RANDOM_REQUESTS = 1620;
  // Pending count above which random traffic stops issuing and cancels instead.
  localparam int unsigned PENDING_CEILING = 96;
  // Command codes the block does not define; it must ignore them with status ok.
  localparam logic [2:0] CMD_SPARE_LO = 3'd5;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  req_t req_i = '0;
  logic done_o;
  res_t res_o;

  request_slot_tracker_top #(
    .SLOTS(SLOTS)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .req_i (req_i),
    .done_o(done_o),
    .res_o (res_o)
  );

  always #5 clk_i = ~clk_i;

  // Shadow copy of the slot table. It is updated at the edge on which each
  // request is accepted, so the expected results queue in acceptance order.
  slot_state_e slot_state_q [SLOTS];
  logic [63:0] slot_handle_q [SLOTS];
  logic [63:0] slot_value_q [SLOTS];
  logic [6:0]  scan_ptr_q = '0;
  int unsigned pending_q = 0;

  res_t        expected_results [$];
  res_t        last_result;
  int unsigned gap_limit = MAX_GAP;
  int unsigned mismatch_count = 0;

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      slot_state_q[i]  = SLOT_IDLE;
      slot_handle_q[i] = '0;
      slot_value_q[i]  = '0;
    end
  end

  // Walk the table from the scan pointer, the pointer itself first. The pointer
  // is left on the slot found; after a fruitless lap it is back where it began.
  // The table is exactly 2**7 slots, so the 7-bit pointer wraps by itself.
  function automatic bit scan_slots(input slot_state_e want, input bit forward,
                                    output logic [6:0] found);
    logic [6:0] origin;
    origin = scan_ptr_q;
    found  = '0;
    do begin
      if (slot_state_q[scan_ptr_q] == want) begin
        found = scan_ptr_q;
        return 1'b1;
      end
      scan_ptr_q = forward ? scan_ptr_q + 7'd1 : scan_ptr_q - 7'd1;
    end while (scan_ptr_q != origin);
    return 1'b0;
  endfunction

  // Works out the result of one request and applies it to the shadow table.
  function automatic res_t predict_request(input req_t r);
    res_t       res;
    logic [6:0] hit;
    res = '0;
    res.status = STS_OK;
    case (r.command)
      CMD_ISSUE: begin
        if (scan_slots(SLOT_IDLE, 1'b1, hit)) begin
          slot_state_q[hit]  = SLOT_PENDING;
          slot_handle_q[hit] = r.request_handle;
          pending_q++;
          res.slot_out = hit;
        end else begin
          res.status = STS_FULL;
        end
      end
      CMD_TAKE: begin
        if (scan_slots(SLOT_PENDING, 1'b0, hit)) begin
          slot_state_q[hit] = SLOT_PROCESSING;
          res.handle_out = slot_handle_q[hit];
          if (pending_q > 0) pending_q--;
          res.slot_out = hit;
        end else begin
          res.status = STS_NONE;
        end
      end
      CMD_CANCEL: begin
        // Cancelling a pending request must also drop it from the pending count.
        if (slot_state_q[r.slot] == SLOT_PENDING && pending_q > 0) pending_q--;
        slot_state_q[r.slot] = SLOT_IDLE;
      end
      CMD_COMPLETE: begin
        if (slot_state_q[r.slot] == SLOT_PROCESSING) begin
          slot_value_q[r.slot] = r.return_value;
          slot_state_q[r.slot] = SLOT_COMPLETE;
        end else begin
          res.status = STS_NOT_PROC;
        end
      end
      CMD_COLLECT: begin
        if (slot_state_q[r.slot] == SLOT_COMPLETE) begin
          res.value_out = slot_value_q[r.slot];
          slot_state_q[r.slot] = SLOT_IDLE;
        end else begin
          res.status = STS_NOT_DONE;
        end
      end
      default: ;
    endcase
    res.pending_out = pending_q[7:0];
    return res;
  endfunction

  // Returns a slot in the given state, starting the search at a random slot,
  // or -1 when there is none.
  function automatic int pick_slot(input slot_state_e st);
    int base;
    base = $urandom_range(0, SLOTS - 1);
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_state_q[(base + i) % SLOTS] == st) return (base + i) % SLOTS;
    end
    return -1;
  endfunction

  // Presents one request after a random gap and holds it until the block takes
  // it. With no gap, start stays high from the previous request, so requests
  // can follow back to back. Busy is read straight after the edge, so it is
  // the value the block saw at that edge.
  task automatic send_request(input logic [2:0] command, input logic [6:0] slot,
                              input logic [63:0] handle, input logic [63:0] value);
    req_t        r;
    int unsigned gap;
    r.command        = command;
    r.slot           = slot;
    r.request_handle = handle;
    r.return_value   = value;
    gap = $urandom_range(0, gap_limit);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    last_result = predict_request(r);
    expected_results.push_back(last_result);
  endtask

  // Stops sending and waits until every outstanding request has reported.
  task automatic drain_requests;
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  // Field extremes, every command, the error statuses other than full and the spare command codes.
  task automatic test_directed;
    logic [6:0] taken;
    // Nothing issued yet, so take must find nothing.
    send_request(CMD_TAKE, '0, '0, '0);
    send_request(CMD_ISSUE, 7'h7f, '1, '0);
    send_request(CMD_ISSUE, '0, '0, '1);
    send_request(CMD_ISSUE, 7'h55, 64'h8000_0000_0000_0001, 64'h5555_aaaa_5555_aaaa);
    send_request(CMD_TAKE, '0, '0, '0);
    taken = last_result.slot_out;
    send_request(CMD_COMPLETE, taken, '0, '1);
    // A second completion finds the slot complete rather than processing.
    send_request(CMD_COMPLETE, taken, '1, '0);
    send_request(CMD_COLLECT, taken, '0, '0);
    // Already collected, so the slot is idle and not ready.
    send_request(CMD_COLLECT, taken, '0, '0);
    send_request(CMD_TAKE, '0, '0, '0);
    taken = last_result.slot_out;
    send_request(CMD_COMPLETE, taken, '0, '0);
    send_request(CMD_COLLECT, taken, '1, '1);
    // Collecting a pending slot is refused; cancelling it lowers the count.
    taken = 7'(pick_slot(SLOT_PENDING));
    send_request(CMD_COLLECT, taken, '0, '0);
    send_request(CMD_CANCEL, taken, '0, '0);
    send_request(CMD_COMPLETE, 7'h7f, '0, '1);
    send_request(CMD_COLLECT, 7'h7f, '0, '0);
    // Cancelling a processing slot frees it without touching the count.
    send_request(CMD_ISSUE, '0, 64'h0123_4567_89ab_cdef, '0);
    send_request(CMD_TAKE, '0, '0, '0);
    send_request(CMD_CANCEL, last_result.slot_out, '0, '0);
    send_request(CMD_CANCEL, 7'h7f, '0, '0);
    for (logic [3:0] c = 4'(CMD_SPARE_LO); c <= 4'(CMD_SPARE_HI); c++) begin
      send_request(c[2:0], 7'h7f, '1, '1);
    end
  endtask

  // Fills every slot, so the pending count reaches its top value and issue
  // reports a full table, then empties the table again by cancelling.
  task automatic test_table_full;
    while (pick_slot(SLOT_IDLE) >= 0) begin
      send_request(CMD_ISSUE, 7'($urandom), {$urandom, $urandom}, {$urandom, $urandom});
    end
    send_request(CMD_ISSUE, '0, '1, '0);
    send_request(CMD_TAKE, '0, '0, '0);
    send_request(CMD_TAKE, '0, '0, '0);
    for (int s = 0; s < SLOTS; s++) begin
      send_request(CMD_CANCEL, 7'(s), '0, '0);
    end
    // A whole lap with nothing pending.
    send_request(CMD_TAKE, '0, '0, '0);
  endtask

  // Mostly well-formed life cycles (issue, take, complete and collect on slots
  // that are in the right state) with random content, plus cancels, requests
  // on slots in the wrong state and spare commands. Every 64 requests the
  // sender chooses anew, at random, between random gaps and back-to-back requests.
  task automatic test_random_traffic(input int unsigned count);
    int unsigned roll;
    int          target;
    logic [2:0]  cmd;
    logic [6:0]  slot;
    for (int unsigned n = 0; n < count; n++) begin
      if (n % 64 == 0) gap_limit = ($urandom_range(0, 2) == 0) ? 0 : MAX_GAP;
      roll   = $urandom_range(0, 99);
      slot   = 7'($urandom);
      target = -1;
      if (roll < 28) begin
        cmd = CMD_ISSUE;
        if (pending_q > PENDING_CEILING) begin
          cmd    = CMD_CANCEL;
          target = pick_slot(SLOT_PENDING);
        end
      end else if (roll < 48) begin
        cmd = CMD_TAKE;
      end else if (roll < 63) begin
        cmd    = CMD_COMPLETE;
        target = pick_slot(SLOT_PROCESSING);
      end else if (roll < 80) begin
        cmd    = CMD_COLLECT;
        target = pick_slot(SLOT_COMPLETE);
      end else if (roll < 88) begin
        cmd = CMD_CANCEL;
      end else if (roll < 95) begin
        cmd = ($urandom_range(0, 1) == 0) ? CMD_COMPLETE : CMD_COLLECT;
      end else begin
        cmd = 3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
      end
      if (target >= 0) slot = 7'(target);
      send_request(cmd, slot, {$urandom, $urandom}, {$urandom, $urandom});
    end
    gap_limit = MAX_GAP;
  endtask

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatch_count++;
    end
  endfunction

  // Results cannot be held off, so each one is taken at the edge that ends its
  // strobe cycle and compared with the oldest expectation.
  always @(posedge clk_i) begin : check_results
    res_t want;
    if (rst_ni && done_o) begin
      if (expected_results.size() == 0) begin
        $error("result with no request outstanding: %p", res_o);
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("status", 64'(want.status), 64'(res_o.status));
        check_field("slot_out", 64'(want.slot_out), 64'(res_o.slot_out));
        check_field("handle_out", want.handle_out, res_o.handle_out);
        check_field("value_out", want.value_out, res_o.value_out);
        check_field("pending_out", 64'(want.pending_out), 64'(res_o.pending_out));
      end
    end
  end

  // Reset once; the block then clears its table with busy high, which the
  // handshake in send_request simply waits out. The sender is brought to a
  // halt between tests until every result has arrived.
  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed;
    drain_requests;
    test_table_full;
    drain_requests;
    test_random_traffic(RANDOM_REQUESTS);
    drain_requests;
    // A full scan is the longest the block can take; nothing may arrive after.
    repeat (SLOTS + 16) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      $error("%0d results never arrived", expected_results.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog, several times the slowest correct run.
  initial begin
    #15ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
